/* rtl/cnfs_pkg.sv */
// ----------------------------------------------------------------------------
// cnfs_pkg - shared constants for the common-neighbor friend suggest unit
// Field widths, command / status / register codes and matrix geometry.
// ----------------------------------------------------------------------------
package cnfs_pkg;

   // matrix geometry
   localparam int MAX_USERS = 64;                 // rows kept, 4..64
   localparam int ROW_W     = 64;                 // bits per row
   localparam int ROW_IDX_W = $clog2(MAX_USERS);  // memory address width

   // item field widths
   localparam int CMD_W  = 2;
   localparam int USER_W = 6;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 7;                     // user counts, thresholds
   localparam int CFG_W  = 7;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 16;                // 14 bits used
   localparam int RSP_DATA_W = 136;               // 131 bits used

   // commands
   localparam logic [CMD_W-1:0] CMD_LINK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNLINK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_DONE        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FRIENDS = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_USER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;

   localparam logic [CNT_W-1:0] USER_COUNT_RESET = 7'd0;
   localparam logic [CNT_W-1:0] THRESHOLD_RESET  = 7'd3;

endpackage

/* rtl/common_neighbor_friend_suggest_unit.sv */
// ----------------------------------------------------------------------------
// common_neighbor_friend_suggest_unit - friendship matrix with link prediction
// Keeps a symmetric friend bit matrix in a one-port-read/one-port-write RAM
// and answers common-neighbor suggestion queries by scanning its rows.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* stream carries one command item {user_b, user_a, cmd}: link,
//    unlink or query. rsp_* stream returns exactly one result item per
//    command: {incidental_mask, suggest_mask, pair_friends, status}.
//  - csr_* write channel sets user_count (index 0) and common_threshold
//    (index 1). It is always ready; write it only while the unit is idle.
//  - One item is in work at a time. Link / unlink: read row a, write row a
//    + read row b, write row b, then load the result. A rejected link /
//    unlink, a failed query or an unused command reads row a and decides.
//    A query scans one row per cycle through the RAM read port, then counts
//    the last row and waits to see the pipe empty. The next item is taken
//    the cycle after its result is loaded.
//  - The result sits in an output register; the next item is accepted while
//    it waits. If the receiver stalls, a finished item holds in the unit
//    until the output register frees up, and req_tready stays low.
//  - Reset clears the control and configuration registers and the per-row
//    valid bits at once; a never-written row reads as zero, no clearing pass.
// ----------------------------------------------------------------------------
module common_neighbor_friend_suggest_unit
   import cnfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] cmd, [7:2] user_a, [13:8] user_b
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [1:0] status, [2] pair_friends,
                                              // [66:3] suggest_mask,
                                              // [130:67] incidental_mask
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,   // waiting for an item; row a read issued on accept
      S_EVAL,   // row a back: decide, write row a, issue row b read
      S_WR_B,   // row b back: write mirrored bit
      S_SCAN,   // query: one row read per cycle, previous row counted
      S_OUT     // hand result to output register
   } state_type;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [USER_W-1:0]  ua_ff, ua_in;
   logic [USER_W-1:0]  ub_ff, ub_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic               pf_ff, pf_in;
   logic [ROW_W-1:0]   row_ff, row_in;       // queried row, active columns only
   logic [ROW_W-1:0]   sug_ff, sug_in;
   logic [ROW_W-1:0]   inc_ff, inc_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;     // next row to issue
   logic               pend_ff, pend_in;     // read in flight for pend_idx
   logic [USER_W-1:0]  pend_idx_ff, pend_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]   user_count_ff;
   logic [CNT_W-1:0]   thr_ff;

   // friend matrix RAM plus per-row valid bits
   logic [ROW_W-1:0]     mem [MAX_USERS];
   logic [MAX_USERS-1:0] row_vld_ff;
   logic [ROW_W-1:0]     rd_raw_ff;
   logic                 rd_vld_ff;

   // RAM control
   logic                 mem_re;
   logic [ROW_IDX_W-1:0] mem_raddr;
   logic                 mem_we;
   logic [ROW_IDX_W-1:0] mem_waddr;
   logic [ROW_W-1:0]     mem_wdata;

   // ------------------------------------------------------------------
   // derived values
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]   act_cnt;
   logic [ROW_W-1:0]   cols;
   logic [ROW_W-1:0]   rd_row;
   logic               a_ok, b_ok, pair_now;
   logic [ROW_W-1:0]   bit_b, bit_a;
   logic [ROW_W-1:0]   common;
   logic [CNT_W-1:0]   shared;
   logic               fr_i;
   logic               req_take;
   logic               out_free;

   function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < ROW_W; k++) begin
         n = n + CNT_W'(v[k]);
      end
      return n;
   endfunction

   // counts above the row count act as the row count
   assign act_cnt = (user_count_ff > CNT_W'(MAX_USERS)) ? CNT_W'(MAX_USERS)
                                                        : user_count_ff;
   assign cols = (act_cnt >= CNT_W'(ROW_W)) ? '1
               : ((ROW_W'(1) << act_cnt) - ROW_W'(1));

   assign rd_row   = rd_vld_ff ? rd_raw_ff : '0;
   assign a_ok     = CNT_W'(ua_ff) < act_cnt;
   assign b_ok     = CNT_W'(ub_ff) < act_cnt;
   assign pair_now = a_ok && b_ok && rd_row[ub_ff];
   assign bit_b    = ROW_W'(1) << ub_ff;
   assign bit_a    = ROW_W'(1) << ua_ff;

   assign common = rd_row & row_ff;
   assign shared = popcount(common);
   assign fr_i   = row_ff[pend_idx_ff];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ua_in        = ua_ff;
      ub_in        = ub_ff;
      status_in    = status_ff;
      pf_in        = pf_ff;
      row_in       = row_ff;
      sug_in       = sug_ff;
      inc_in       = inc_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = ua_ff[ROW_IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = ua_ff[ROW_IDX_W-1:0];
      mem_wdata    = rd_row;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_tdata[1:0];
               ua_in     = req_tdata[7:2];
               ub_in     = req_tdata[13:8];
               status_in = STAT_DONE;
               pf_in     = 1'b0;
               sug_in    = '0;
               inc_in    = '0;
               mem_re    = 1'b1;
               mem_raddr = req_tdata[ROW_IDX_W+1:2];
               state_in  = S_EVAL;
            end
         end

         S_EVAL: begin
            priority if (cmd_ff == CMD_LINK || cmd_ff == CMD_UNLINK) begin
               if (!a_ok || !b_ok || ua_ff == ub_ff) begin
                  status_in = STAT_BAD_INDEX;
                  state_in  = S_OUT;
               end else if (cmd_ff == CMD_UNLINK && !pair_now) begin
                  status_in = STAT_NOT_FRIENDS;
                  state_in  = S_OUT;
               end else begin
                  // write row a, fetch row b for the mirrored bit
                  mem_we    = 1'b1;
                  mem_wdata = (cmd_ff == CMD_LINK) ? (rd_row | bit_b)
                                                   : (rd_row & ~bit_b);
                  pf_in     = (cmd_ff == CMD_LINK);
                  mem_re    = 1'b1;
                  mem_raddr = ub_ff[ROW_IDX_W-1:0];
                  state_in  = S_WR_B;
               end
            end else if (cmd_ff == CMD_QUERY) begin
               pf_in = pair_now;
               if (!a_ok) begin
                  status_in = STAT_BAD_INDEX;
                  state_in  = S_OUT;
               end else begin
                  row_in   = rd_row & cols;
                  scan_in  = '0;
                  state_in = S_SCAN;
               end
            end else begin
               // unused command: report pair only
               pf_in    = pair_now;
               state_in = S_OUT;
            end
         end

         S_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = ub_ff[ROW_IDX_W-1:0];
            mem_wdata = (cmd_ff == CMD_LINK) ? (rd_row | bit_a)
                                             : (rd_row & ~bit_a);
            state_in  = S_OUT;
         end

         S_SCAN: begin
            // count the row that came back
            if (pend_ff && pend_idx_ff != ua_ff) begin
               if (!fr_i && shared >= thr_ff) begin
                  sug_in[pend_idx_ff] = 1'b1;
               end
               if (fr_i && shared == '0) begin
                  inc_in[pend_idx_ff] = 1'b1;
               end
            end
            if (scan_ff < act_cnt) begin
               mem_re      = 1'b1;
               mem_raddr   = scan_ff[ROW_IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[USER_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, inc_ff, sug_ff, pf_ff, status_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // state and result registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      ua_ff       <= ua_in;
      ub_ff       <= ub_in;
      status_ff   <= status_in;
      pf_ff       <= pf_in;
      row_ff      <= row_in;
      sug_ff      <= sug_in;
      inc_ff      <= inc_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         user_count_ff <= USER_COUNT_RESET;
         thr_ff        <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_USER_COUNT) begin
            user_count_ff <= csr_data;
         end
         if (csr_index == CSR_THRESHOLD) begin
            thr_ff <= csr_data;
         end
      end
   end

   // ------------------------------------------------------------------
   // friend matrix RAM: registered read, rows valid once written
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_raw_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            row_vld_ff[mem_waddr] <= 1'b1;
         end
         if (mem_re) begin
            rd_vld_ff <= row_vld_ff[mem_raddr];
         end
      end
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("unit idle right after taking an item");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_EVAL || state_ff == S_WR_B))
      else $error("matrix written outside link/unlink states");

   a_mirror_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR_B) |-> (ua_ff != ub_ff))
      else $error("mirror write for a self pair");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("scan read left in flight");

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[66:3] & rsp_data_ff[130:67]) == '0))
      else $error("user both suggested and incidental");

endmodule
